// File: design/binomial_lattice_option_pricer_macros.svh
// Assertion macros shared by the option pricer RTL.
`ifndef BINOMIAL_LATTICE_OPTION_PRICER_MACROS_SVH
`define BINOMIAL_LATTICE_OPTION_PRICER_MACROS_SVH

// Checks that cons holds in the same cycle as ante, outside reset.
`define BLOP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante, outside reset.
`define BLOP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/blop_pkg.sv
// Shared widths, register codes and arithmetic helpers of the option pricer.
`timescale 1ns / 1ps
`default_nettype none

package blop_pkg;

  // Lattice size and storage geometry
  localparam int unsigned MAX_STEPS  = 1024;
  localparam int unsigned NODE_DEPTH = MAX_STEPS + 1;
  localparam int unsigned ADDR_W     = $clog2(NODE_DEPTH);

  // Fixed field widths
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned PROD_W      = 2 * WORD_W;
  localparam int unsigned STEP_W      = 11;
  localparam int unsigned DOWN_W      = 31;
  localparam int unsigned FACTOR_FRAC = 30;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Register reset values
  localparam logic [STEP_W-1:0] STEP_RESET   = 11'd64;
  localparam logic [WORD_W-1:0] UNIT_FACTOR  = 32'h4000_0000;
  localparam logic [WORD_W-1:0] HALF_WEIGHT  = 32'h8000_0000;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COUNT  = 3'd0,
    CFG_UP_FACTOR   = 3'd1,
    CFG_DOWN_FACTOR = 3'd2,
    CFG_WEIGHT_UP   = 3'd3,
    CFG_WEIGHT_DOWN = 3'd4
  } cfg_idx_e;

  // A word together with its saturation indication
  typedef struct packed {
    logic  sat;
    word_t val;
  } sat_word_t;

  // Clamps the configured step count to the lattice capacity.
  function automatic logic [ADDR_W-1:0] clamp_steps(input logic [STEP_W-1:0] steps);
    if (int'(steps) > int'(MAX_STEPS)) begin
      return ADDR_W'(MAX_STEPS);
    end
    return ADDR_W'(steps);
  endfunction

  // Price times Q2.30 factor: round half up, then saturate to one word.
  function automatic sat_word_t round_factor(input logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0] r;
    sat_word_t         res;
    r       = (prod + (PROD_W'(1) << (FACTOR_FRAC - 1))) >> FACTOR_FRAC;
    res.sat = |r[PROD_W-1:WORD_W];
    res.val = res.sat ? '1 : r[WORD_W-1:0];
    return res;
  endfunction

  // Sum of two Q0.32-weighted values: exact sum, round half up, saturate.
  function automatic sat_word_t round_weigh(input logic [PROD_W-1:0] p1,
                                            input logic [PROD_W-1:0] p2);
    logic [PROD_W:0] s;
    sat_word_t       res;
    s       = {1'b0, p1} + {1'b0, p2} + ((PROD_W + 1)'(1) << (WORD_W - 1));
    res.sat = |s[PROD_W:2*WORD_W];
    res.val = res.sat ? '1 : s[2*WORD_W-1:WORD_W];
    return res;
  endfunction

  // Exercise value of a call or a put.
  function automatic word_t payoff(input word_t asset, input word_t strike,
                                   input logic call);
    if (call) begin
      return (asset > strike) ? asset - strike : '0;
    end
    return (strike > asset) ? strike - asset : '0;
  endfunction

endpackage

`default_nettype wire

// File: design/blop_if.sv
// Handshake channels for option beats in and price beats out.
`timescale 1ns / 1ps
`default_nettype none

interface blop_opt_if
  import blop_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t spot_price;
  word_t strike_price;
  logic  is_call;
  logic  early_exercise;

  modport source (output valid, output spot_price, output strike_price,
                  output is_call, output early_exercise, input ready);
  modport sink   (input valid, input spot_price, input strike_price,
                  input is_call, input early_exercise, output ready);
endinterface

interface blop_res_if
  import blop_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t option_price;
  logic  saturated;

  modport source (output valid, output option_price, output saturated, input ready);
  modport sink   (input valid, input option_price, input saturated, output ready);
endinterface

`default_nettype wire

// File: design/blop_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module blop_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1025,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/binomial_lattice_option_pricer.sv
// Top level of the binomial lattice option pricer.
`timescale 1ns / 1ps
`default_nettype none
`include "binomial_lattice_option_pricer_macros.svh"
// Usage:
// One beat on opt_i carries one option (spot, strike, call or put, European
// or American); one beat on res_o later returns its root price and a flag
// that is set when any node price or value saturated. The user must write
// configuration through cfg_we_i, cfg_idx_i and cfg_data_i only while the
// block is idle; the block itself does not enforce this. Options are priced
// one at a time. The up chain builds the top terminal price, down steps fill
// the rest of the terminal layer, and the backward induction streams one node
// per cycle within a level through the node memories, each level draining
// before the next level reads back what it wrote.
// The node memories hold no reset state; every entry is written before it
// is read. Reset loads the default configuration and empties the output.
// The finished price sits in an output register; when the receiver stalls,
// the block waits with the next price until that register is taken, and
// it accepts a new option as soon as it has handed the price over.
module binomial_lattice_option_pricer
  import blop_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  blop_opt_if.sink                   opt_i,
  blop_res_if.source                 res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_RND,
    ST_TM_MUL,
    ST_TM_RND,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Configuration registers
  logic [STEP_W-1:0] step_count_q;
  word_t             up_factor_q;
  logic [DOWN_W-1:0] down_factor_q;
  word_t             weight_up_q;
  word_t             weight_down_q;

  // Control state
  state_e            state_q;
  word_t             a_q;
  word_t             strike_q;
  logic              call_q;
  logic              american_q;
  logic [ADDR_W-1:0] n_q;
  logic [ADDR_W-1:0] k_q;
  logic [ADDR_W-1:0] i_q;
  logic              half_q;
  logic [ADDR_W-1:0] level_q;
  logic [ADDR_W-1:0] j_q;
  logic              sat_q;
  word_t             last_v_q;
  logic              res_valid_q;
  word_t             res_price_q;
  logic              res_sat_q;

  // Induction pipeline
  logic              vld1_q, vld2_q, vld3_q;
  logic [ADDR_W-1:0] j1_q, i2_q, i3_q;
  word_t             prev_v_q, prev_a_q;
  logic [PROD_W-1:0] vp1_q, vp2_q, fprod_q;
  word_t             cont3_q, asset3_q;
  logic              sat3_q;

  // Memory ports
  logic              rd_en;
  word_t             v_rdata, a_rdata;
  logic              v_we, a_we;
  logic [ADDR_W-1:0] wr_addr;
  word_t             v_wdata, a_wdata;

  // Datapath nets
  word_t             mul_a, mul_b, down_word;
  sat_word_t         rnd, wsum;
  word_t             term_asset, term_value, ex_value, node_val;
  logic              term_wr;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q  <= STEP_RESET;
      up_factor_q   <= UNIT_FACTOR;
      down_factor_q <= UNIT_FACTOR[DOWN_W-1:0];
      weight_up_q   <= HALF_WEIGHT;
      weight_down_q <= HALF_WEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_COUNT:  step_count_q  <= cfg_data_i[STEP_W-1:0];
        CFG_UP_FACTOR:   up_factor_q   <= cfg_data_i[WORD_W-1:0];
        CFG_DOWN_FACTOR: down_factor_q <= cfg_data_i[DOWN_W-1:0];
        CFG_WEIGHT_UP:   weight_up_q   <= cfg_data_i[WORD_W-1:0];
        CFG_WEIGHT_DOWN: weight_down_q <= cfg_data_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign down_word = {{(WORD_W - DOWN_W){1'b0}}, down_factor_q};

  // The factor multiplier is shared by the terminal build and the asset step-back
  always_comb begin
    case (state_q)
      ST_UP: begin
        mul_a = a_q;
        mul_b = up_factor_q;
      end
      ST_TM_MUL: begin
        mul_a = a_q;
        mul_b = down_word;
      end
      default: begin
        mul_a = prev_a_q;
        mul_b = down_word;
      end
    endcase
  end

  assign rnd  = round_factor(fprod_q);
  assign wsum = round_weigh(vp1_q, vp2_q);

  // Terminal node writes: the top node after the up chain, the rest after two down steps
  assign term_asset = (state_q == ST_UP) ? a_q : rnd.val;
  assign term_value = payoff(term_asset, strike_q, call_q);
  assign term_wr    = ((state_q == ST_UP) && (k_q == n_q)) ||
                      ((state_q == ST_TM_RND) && half_q);

  // Last induction stage: early exercise against continuation
  assign ex_value = payoff(asset3_q, strike_q, call_q);
  assign node_val = (american_q && (ex_value > cont3_q)) ? ex_value : cont3_q;

  // Memory write and read selection
  assign rd_en   = (state_q == ST_ISSUE);
  assign v_we    = term_wr || vld3_q;
  assign a_we    = term_wr || (vld3_q && american_q);
  assign wr_addr = vld3_q ? i3_q : ((state_q == ST_UP) ? '0 : i_q);
  assign v_wdata = vld3_q ? node_val : term_value;
  assign a_wdata = vld3_q ? asset3_q : term_asset;

  blop_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NODE_DEPTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (wr_addr),
    .wdata_i (v_wdata),
    .re_i    (rd_en),
    .raddr_i (j_q),
    .rdata_o (v_rdata)
  );

  blop_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NODE_DEPTH)
  ) u_asset_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (wr_addr),
    .wdata_i (a_wdata),
    .re_i    (rd_en),
    .raddr_i (j_q),
    .rdata_o (a_rdata)
  );

  // Pipeline valid flags; a node exists once two neighbouring values are read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= rd_en;
      vld2_q <= vld1_q && (j1_q != '0);
      vld3_q <= vld2_q;
    end
  end

  // Pipeline payload: products, then rounding, then the write-back stage
  always_ff @(posedge clk_i) begin
    j1_q <= j_q;
    i2_q <= j1_q - ADDR_W'(1);
    i3_q <= i2_q;
    if (vld1_q) begin
      prev_v_q <= v_rdata;
      prev_a_q <= a_rdata;
    end
    vp1_q    <= PROD_W'(weight_up_q) * PROD_W'(prev_v_q);
    vp2_q    <= PROD_W'(weight_down_q) * PROD_W'(v_rdata);
    fprod_q  <= PROD_W'(mul_a) * PROD_W'(mul_b);
    cont3_q  <= wsum.val;
    asset3_q <= rnd.val;
    sat3_q   <= wsum.sat || (american_q && rnd.sat);
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_q         <= '0;
      strike_q    <= '0;
      call_q      <= 1'b0;
      american_q  <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      half_q      <= 1'b0;
      level_q     <= '0;
      j_q         <= '0;
      sat_q       <= 1'b0;
      last_v_q    <= '0;
      res_valid_q <= 1'b0;
      res_price_q <= '0;
      res_sat_q   <= 1'b0;
    end else begin
      // A taken beat empties the output register unless a new price replaces it
      if (res_o.ready && (state_q != ST_DONE)) begin
        res_valid_q <= 1'b0;
      end
      if (vld3_q) begin
        sat_q    <= sat_q || sat3_q;
        last_v_q <= node_val;
      end
      case (state_q)
        ST_IDLE: begin
          if (opt_i.valid) begin
            a_q        <= opt_i.spot_price;
            strike_q   <= opt_i.strike_price;
            call_q     <= opt_i.is_call;
            american_q <= opt_i.early_exercise;
            n_q        <= clamp_steps(step_count_q);
            k_q        <= '0;
            sat_q      <= 1'b0;
            state_q    <= ST_UP;
          end
        end
        ST_UP: begin
          if (k_q == n_q) begin
            last_v_q <= term_value;
            i_q      <= ADDR_W'(1);
            half_q   <= 1'b0;
            state_q  <= (n_q == '0) ? ST_DONE : ST_TM_MUL;
          end else begin
            state_q <= ST_UP_RND;
          end
        end
        ST_UP_RND: begin
          a_q     <= rnd.val;
          sat_q   <= sat_q || rnd.sat;
          k_q     <= k_q + ADDR_W'(1);
          state_q <= ST_UP;
        end
        ST_TM_MUL: begin
          state_q <= ST_TM_RND;
        end
        ST_TM_RND: begin
          a_q   <= rnd.val;
          sat_q <= sat_q || rnd.sat;
          if (!half_q) begin
            half_q  <= 1'b1;
            state_q <= ST_TM_MUL;
          end else begin
            half_q   <= 1'b0;
            last_v_q <= term_value;
            if (i_q == n_q) begin
              level_q <= n_q;
              j_q     <= '0;
              state_q <= ST_ISSUE;
            end else begin
              i_q     <= i_q + ADDR_W'(1);
              state_q <= ST_TM_MUL;
            end
          end
        end
        ST_ISSUE: begin
          if (j_q == level_q) begin
            state_q <= ST_DRAIN;
          end else begin
            j_q <= j_q + ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          // The next level reads what this one writes, so let it land first
          if (!(vld1_q || vld2_q || vld3_q)) begin
            if (level_q == ADDR_W'(1)) begin
              state_q <= ST_DONE;
            end else begin
              level_q <= level_q - ADDR_W'(1);
              j_q     <= '0;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_DONE: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_price_q <= last_v_q;
            res_sat_q   <= sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Channel outputs
  assign opt_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = res_valid_q;
  assign res_o.option_price = res_price_q;
  assign res_o.saturated    = res_sat_q;

  // Assertions
  `BLOP_ASSERT_SAME(a_level_start_empty, (state_q == ST_ISSUE) && (j_q == '0), !(vld1_q || vld2_q || vld3_q), "level started with nodes still in flight")
  `BLOP_ASSERT_SAME(a_node_within_level, vld3_q, i3_q < level_q, "node write beyond the current level")
  `BLOP_ASSERT_SAME(a_result_from_done, $rose(res_valid_q), $past(state_q == ST_DONE), "result beat raised outside completion")
  `BLOP_ASSERT_NEXT(a_accept_clears_flag, opt_i.valid && opt_i.ready, (state_q == ST_UP) && !sat_q, "option accepted without a fresh start")

endmodule

`default_nettype wire

// File: bench/blop_price_checker.sv
// Monitor and predictor for the option pricer: watches both channels and checks every price beat.
`timescale 1ns / 1ps

module blop_price_checker
  import blop_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  blop_opt_if                   opt_i,
  blop_res_if                   res_i,
  output int unsigned           outstanding_o,
  output int unsigned           error_count_o
);

  typedef struct packed {
    word_t price;
    logic  sat;
  } price_beat_t;

  // Shadow copy of the configuration registers.
  logic [STEP_W-1:0] lattice_steps;
  word_t             rise_factor;
  logic [DOWN_W-1:0] fall_factor;
  word_t             rise_weight;
  word_t             fall_weight;

  // Scratch lattice of the predictor and its saturation flag.
  word_t node_worth [NODE_DEPTH];
  word_t node_spot  [NODE_DEPTH];
  logic  clipped;

  price_beat_t expected_prices [$];
  int unsigned mismatches = 0;
  int unsigned price_index = 0;

  assign error_count_o = mismatches;

  // Price times a Q2.30 factor, rounded half up and clipped to one word.
  function automatic word_t apply_factor(input word_t price, input word_t factor);
    logic [64:0] scaled;
    scaled = (65'(price) * 65'(factor) + (65'(1) << (FACTOR_FRAC - 1))) >> FACTOR_FRAC;
    if (|scaled[64:32]) begin
      clipped = 1'b1;
      return '1;
    end
    return scaled[31:0];
  endfunction

  // Discounted expectation of the two child values, exact sum rounded half up.
  function automatic word_t blend_worth(input word_t upper, input word_t lower);
    logic [64:0] total;
    total = 65'(rise_weight) * 65'(upper) + 65'(fall_weight) * 65'(lower)
            + (65'(1) << 31);
    if (total[64]) begin
      clipped = 1'b1;
      return '1;
    end
    return total[63:32];
  endfunction

  function automatic word_t exercise_value(input word_t asset, input word_t strike,
                                           input logic call);
    if (call) begin
      return (asset > strike) ? asset - strike : '0;
    end
    return (strike > asset) ? strike - asset : '0;
  endfunction

  // Prices one option on the whole lattice with the current configuration.
  function automatic price_beat_t price_option(input word_t spot, input word_t strike,
                                               input logic call, input logic american);
    int unsigned depth;
    int unsigned i;
    int unsigned lvl;
    word_t       worth;
    word_t       exercise;
    price_beat_t beat;
    clipped = 1'b0;
    depth   = (lattice_steps > MAX_STEPS) ? MAX_STEPS : int'(lattice_steps);

    // Terminal layer: top node climbs by u, each lower node is two d moves down.
    node_spot[0] = spot;
    for (i = 0; i < depth; i++) begin
      node_spot[0] = apply_factor(node_spot[0], rise_factor);
    end
    for (i = 1; i <= depth; i++) begin
      worth        = apply_factor(node_spot[i-1], word_t'(fall_factor));
      node_spot[i] = apply_factor(worth, word_t'(fall_factor));
    end
    for (i = 0; i <= depth; i++) begin
      node_worth[i] = exercise_value(node_spot[i], strike, call);
    end

    // Backward induction; American options step each node's price back by d.
    for (lvl = depth; lvl > 0; lvl--) begin
      for (i = 0; i < lvl; i++) begin
        worth = blend_worth(node_worth[i], node_worth[i+1]);
        if (american) begin
          node_spot[i] = apply_factor(node_spot[i], word_t'(fall_factor));
          exercise     = exercise_value(node_spot[i], strike, call);
          if (exercise > worth) begin
            worth = exercise;
          end
        end
        node_worth[i] = worth;
      end
    end

    beat.price = node_worth[0];
    beat.sat   = clipped;
    return beat;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] price beat %0d mismatch: %s", $time, price_index, what);
  endtask

  // Track register writes, predict on each option beat, compare on each price beat.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    price_beat_t seen;
    price_beat_t want;
    if (!rst_ni) begin
      lattice_steps = STEP_RESET;
      rise_factor   = UNIT_FACTOR;
      fall_factor   = UNIT_FACTOR[DOWN_W-1:0];
      rise_weight   = HALF_WEIGHT;
      fall_weight   = HALF_WEIGHT;
      expected_prices.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_COUNT:  lattice_steps = cfg_data_i[STEP_W-1:0];
          CFG_UP_FACTOR:   rise_factor   = cfg_data_i;
          CFG_DOWN_FACTOR: fall_factor   = cfg_data_i[DOWN_W-1:0];
          CFG_WEIGHT_UP:   rise_weight   = cfg_data_i;
          CFG_WEIGHT_DOWN: fall_weight   = cfg_data_i;
          default: ;
        endcase
      end
      if (opt_i.valid && opt_i.ready) begin
        expected_prices.push_back(price_option(opt_i.spot_price, opt_i.strike_price,
                                               opt_i.is_call, opt_i.early_exercise));
      end
      if (res_i.valid && res_i.ready) begin
        seen.price = res_i.option_price;
        seen.sat   = res_i.saturated;
        if (expected_prices.size() == 0) begin
          report_mismatch($sformatf("price %h arrived with no option pending", seen.price));
        end else begin
          want = expected_prices.pop_front();
          if (seen.price !== want.price) begin
            report_mismatch($sformatf("option_price %h, predicted %h", seen.price,
                                      want.price));
          end
          if (seen.sat !== want.sat) begin
            report_mismatch($sformatf("saturated %b, predicted %b", seen.sat, want.sat));
          end
        end
        price_index++;
      end
      outstanding_o <= expected_prices.size();
    end
  end

endmodule

// File: bench/tb_binomial_lattice_option_pricer.sv
// Testbench top of the option pricer: configuration, option stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps

module tb_binomial_lattice_option_pricer;
  import blop_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_OPTIONS = 25;
  localparam int unsigned HOLD_PHASE    = 3;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned IDLE_LIMIT    = 2_000_000;
  localparam int unsigned TAIL_CYCLES   = 3000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           outstanding;
  int unsigned           mismatches;
  int unsigned           burst_left   = 0;
  int unsigned           idle_cycles  = 0;
  logic                  hold_request = 1'b0;

  blop_opt_if opt_ch ();
  blop_res_if res_ch ();

  binomial_lattice_option_pricer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .opt_i      (opt_ch),
    .res_o      (res_ch)
  );

  blop_price_checker price_watch (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .opt_i         (opt_ch),
    .res_i         (res_ch),
    .outstanding_o (outstanding),
    .error_count_o (mismatches)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Receiver: random stall pattern, free-running stretches, and one long hold-off on request.
  initial begin : result_receiver
    res_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        res_ch.ready <= 1'b0;
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 150)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((opt_ch.valid && opt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_binomial_lattice_option_pricer: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Writes every register, plus one write to an unmapped index that must be ignored.
  task automatic load_lattice(input logic [31:0] steps, input logic [31:0] up,
                              input logic [31:0] down, input logic [31:0] wu,
                              input logic [31:0] wd);
    write_reg(CFG_STEP_COUNT, steps);
    write_reg(CFG_UP_FACTOR, up);
    write_reg(CFG_DOWN_FACTOR, down);
    write_reg(CFG_WEIGHT_UP, wu);
    write_reg(CFG_WEIGHT_DOWN, wd);
    write_reg(CFG_UNMAPPED, $urandom());
    cfg_we <= 1'b0;
  endtask

  // Sends one option beat; the sender works in bursts separated by random gaps.
  task automatic offer_option(input word_t spot, input word_t strike, input logic call,
                              input logic american);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 6);
      opt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opt_ch.valid          <= 1'b1;
    opt_ch.spot_price     <= spot;
    opt_ch.strike_price   <= strike;
    opt_ch.is_call        <= call;
    opt_ch.early_exercise <= american;
    @(posedge clk iff (opt_ch.valid && opt_ch.ready));
    burst_left--;
  endtask

  // Stops offering and waits until every predicted price has been delivered.
  task automatic await_prices();
    opt_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk iff (outstanding == 0));
  endtask

  // One random configuration followed by a stream of options.
  task automatic random_phase(input int unsigned phase);
    logic [31:0] steps;
    logic [31:0] up;
    logic [31:0] down;
    logic [31:0] total;
    logic [31:0] wu;
    word_t       strike;
    word_t       spot;
    int unsigned pick;
    pick  = $urandom_range(0, 9);
    steps = (pick == 0) ? 32'd0 :
            (pick <= 6) ? $urandom_range(1, 8) :
            (pick <= 8) ? $urandom_range(9, 20) : $urandom_range(21, 40);
    // The hold-off phase uses a short lattice so that the block backs up quickly.
    if (phase == HOLD_PHASE) begin
      steps = 32'd2;
    end
    if (phase % 4 == 2) begin
      // Arbitrary factors and weights, saturation likely.
      load_lattice(steps, $urandom(), $urandom(), $urandom(), $urandom());
    end else begin
      up    = 32'h4000_0000 + $urandom_range(0, 32'h1000_0000);
      down  = 32'((64'h1 << 60) / up);
      total = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
      wu    = $urandom_range(total / 4, total / 4 * 3);
      load_lattice(steps, up, down, wu, total - wu);
    end
    if (phase == HOLD_PHASE) begin
      hold_request = 1'b1;
    end
    repeat (PHASE_OPTIONS) begin
      if ($urandom_range(0, 3) == 0) begin
        offer_option($urandom(), $urandom(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end else begin
        strike = $urandom_range(32'h0001_0000, 32'h0400_0000);
        spot   = $urandom_range(strike / 2, strike + strike / 2);
        offer_option(spot, strike, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    await_prices();
  endtask

  initial begin : stimulus
    int unsigned phase;
    opt_ch.valid          = 1'b0;
    opt_ch.spot_price     = '0;
    opt_ch.strike_price   = '0;
    opt_ch.is_call        = 1'b0;
    opt_ch.early_exercise = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = '0;
    cfg_data              = '0;
    rst_n                 = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: unit factors, so every node carries the spot price.
    offer_option(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0);
    offer_option(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
    offer_option(32'h0064_0000, 32'h0064_0000, 1'b1, 1'b1);
    await_prices();

    // A realistic eight-step lattice: every payoff and exercise style, field extremes.
    load_lattice(32'd8, 32'd1127428915, 32'd1022611260, 32'd2104533975, 32'd2186155065);
    offer_option(32'h0064_0000, 32'h005F_0000, 1'b1, 1'b0);
    offer_option(32'h0064_0000, 32'h0069_0000, 1'b0, 1'b0);
    offer_option(32'h0064_0000, 32'h005F_0000, 1'b1, 1'b1);
    offer_option(32'h0064_0000, 32'h0069_0000, 1'b0, 1'b1);
    offer_option(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1);
    offer_option(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
    offer_option(32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0);
    offer_option(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    await_prices();

    // Zero steps: the price is the payoff of the spot itself.
    load_lattice(32'd0, 32'd1127428915, 32'd1022611260, 32'd2104533975, 32'd2186155065);
    offer_option(32'h0080_0000, 32'h0040_0000, 1'b1, 1'b0);
    offer_option(32'h0020_0000, 32'h0040_0000, 1'b0, 1'b1);
    await_prices();

    // One step, down factor at its widest (top bit masked off), weights at both ends.
    load_lattice(32'd1, 32'h4000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    offer_option(32'h0001_0000, 32'h0000_8000, 1'b1, 1'b1);
    offer_option(32'h0001_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
    offer_option(32'h0001_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
    await_prices();

    // Step count beyond capacity clamps to the full lattice; extreme factors saturate.
    load_lattice(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_option(32'h0001_0000, 32'h0002_0000, 1'b0, 1'b1);
    await_prices();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_phase(phase);
    end

    // Quiet tail to catch any stray price beat.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_binomial_lattice_option_pricer: clean");
    end else begin
      $display("tb_binomial_lattice_option_pricer: errors");
    end
    $finish;
  end

endmodule
